/* hdl/utrq_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// utrq_pkg
// Shared types, codes and the port base table for the UART transfer request
// queue.
// ---------------------------------------------------------------------------
package utrq_pkg;

  localparam int SLOTS_DEF       = 8;
  localparam int ADDR_WIDTH_DEF  = 32;
  localparam int COUNT_WIDTH_DEF = 16;

  // command codes
  localparam logic CMD_SUBMIT = 1'b0;
  localparam logic CMD_INTR   = 1'b1;

  // transfer direction
  localparam logic DIR_WRITE = 1'b0;
  localparam logic DIR_READ  = 1'b1;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_NO_CUR   = 3'd2;
  localparam logic [2:0] ST_NOT_PEND = 3'd3;
  localparam logic [2:0] ST_ZERO_CNT = 3'd4;

  // data action codes
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_STORE = 3'd1;
  localparam logic [2:0] ACT_FETCH = 3'd2;
  localparam logic [2:0] ACT_LSR   = 3'd3;
  localparam logic [2:0] ACT_MSR   = 3'd4;

  // interrupt identification codes (iir bits 3:1)
  localparam logic [2:0] IID_MSR  = 3'd0;
  localparam logic [2:0] IID_THRE = 3'd1;
  localparam logic [2:0] IID_RDA  = 3'd2;
  localparam logic [2:0] IID_RLS  = 3'd3;

  // interrupt enable bits
  localparam logic [3:0] IER_RX = 4'h1;
  localparam logic [3:0] IER_TX = 4'h2;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  port_sel;
    logic        direction;
    logic [15:0] byte_count;
    logic [31:0] buffer_address;
    logic [7:0]  iir_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  data_action;
    logic [31:0] data_address;
    logic [9:0]  io_base;
    logic        done_res;
    logic [2:0]  done_slot;
    logic        tx_int_off;
    logic        start_valid;
    logic [2:0]  start_slot;
    logic [9:0]  start_io_base;
    logic [3:0]  start_ier_bits;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic start;
    logic push;
  } utrq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_start;
    logic out_free;
  } utrq_sts_t;

  function automatic logic [9:0] port_base(input logic [1:0] port);
    logic [9:0] base;
    case (port)
      2'd0:    base = 10'h3F8;
      2'd1:    base = 10'h2F8;
      2'd2:    base = 10'h3E8;
      2'd3:    base = 10'h2E8;
      default: base = 10'h3F8;
    endcase
    return base;
  endfunction

endpackage
`default_nettype wire

/* hdl/uart_transfer_request_queue_unit.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// uart_transfer_request_queue_unit
// Transfer descriptor queue for a UART: submits and interrupt events in,
// one result beat out per input beat.
// ---------------------------------------------------------------------------
// Each input beat produces exactly one result beat. An item passes through
// capture, execute and hand-off on its way to the output register, with a
// start step between execute and hand-off when finishing a request starts
// the next waiting one, so that the started request is looked up after the
// head has advanced. The input is not ready again until the
// result has moved into the output register; a result held there while the
// consumer stalls does not block the next input beat.
module uart_transfer_request_queue_unit
  import utrq_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  utrq_cmd_t cmd;
  utrq_sts_t sts;

  utrq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  utrq_dp #(
    .SLOTS       (SLOTS),
    .ADDR_WIDTH  (ADDR_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* hdl/utrq_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// utrq_ctrl
// Sequencer: takes a beat, runs it through the datapath, optionally reports
// the next started request, then hands the result to the output register.
// ---------------------------------------------------------------------------
module utrq_ctrl
  import utrq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire utrq_sts_t sts,
  output utrq_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_START,
    S_PUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = sts.need_start ? S_START : S_PUSH;
      S_START: state_nxt = S_PUSH;
      S_PUSH:  if (sts.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready    = (state_r == S_IDLE);
  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.exec    = (state_r == S_EXEC);
  assign cmd.start   = (state_r == S_START);
  assign cmd.push    = (state_r == S_PUSH) && sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/utrq_dp.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// utrq_dp
// Descriptor table, slot order FIFO, result build and output register.
// ---------------------------------------------------------------------------
module utrq_dp
  import utrq_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire utrq_cmd_t cmd,
  output utrq_sts_t      sts,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int PTR_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(SLOTS - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  in_item_t in_r;

  logic [ADDR_WIDTH-1:0]  slot_addr_r [SLOTS];
  logic [COUNT_WIDTH-1:0] slot_rem_r  [SLOTS];
  logic [1:0]             slot_port_r [SLOTS];
  logic                   slot_dir_r  [SLOTS];
  logic [SLOTS-1:0]       slot_free_r;
  logic [PTR_W-1:0]       fifo_r      [SLOTS];
  logic [PTR_W-1:0]       head_r;
  logic [PTR_W-1:0]       tail_r;
  logic [CNT_W-1:0]       count_r;

  out_item_t res_r;
  out_item_t res_nxt;
  out_item_t out_r;
  logic      out_valid_r;

  logic [PTR_W-1:0]       free_idx;
  logic                   any_free;
  logic [PTR_W-1:0]       cur_slot;
  logic [ADDR_WIDTH-1:0]  cur_addr;
  logic [COUNT_WIDTH-1:0] cur_rem;
  logic [1:0]             cur_port;
  logic                   cur_dir;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [COUNT_WIDTH-1:0] rem_dec;
  logic [2:0]             iid;
  logic                   is_intr;
  logic                   submit_ok;
  logic                   intr_ok;
  logic                   data_move;
  logic                   finish;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_free_r[i]) free_idx = PTR_W'(i);
    end
  end

  assign any_free  = |slot_free_r;
  assign cur_slot  = fifo_r[head_r];
  assign cur_addr  = slot_addr_r[cur_slot];
  assign cur_rem   = slot_rem_r[cur_slot];
  assign cur_port  = slot_port_r[cur_slot];
  assign cur_dir   = slot_dir_r[cur_slot];
  assign cnt       = COUNT_WIDTH'(in_r.byte_count);
  assign rem_dec   = cur_rem - COUNT_WIDTH'(1);
  assign iid       = in_r.iir_value[3:1];
  assign is_intr   = (in_r.cmd == CMD_INTR);
  assign submit_ok = !is_intr && (cnt != '0) && any_free;
  assign intr_ok   = is_intr && (count_r != '0) && !in_r.iir_value[0];
  assign data_move = intr_ok && ((iid == IID_RDA) || (iid == IID_THRE));
  assign finish    = data_move && (rem_dec == '0);

  // another request waits behind the one finishing now
  assign sts.need_start = finish && (count_r != CNT_W'(1));
  assign sts.out_free   = !out_valid_r || out_ready;

  always_comb begin
    res_nxt = '0;
    if (!is_intr) begin
      if (cnt == '0) begin
        res_nxt.status = ST_ZERO_CNT;
      end else if (!any_free) begin
        res_nxt.status = ST_FULL;
      end else begin
        res_nxt.status = ST_OK;
        if (count_r == '0) begin
          res_nxt.start_valid    = 1'b1;
          res_nxt.start_slot     = 3'(free_idx);
          res_nxt.start_io_base  = port_base(in_r.port_sel);
          res_nxt.start_ier_bits = (in_r.direction == DIR_READ) ? IER_RX : IER_TX;
        end
      end
    end else if (count_r == '0) begin
      res_nxt.status = ST_NO_CUR;
    end else if (in_r.iir_value[0]) begin
      res_nxt.status = ST_NOT_PEND;
    end else begin
      res_nxt.status  = ST_OK;
      res_nxt.io_base = port_base(cur_port);
      case (iid)
        IID_RLS:  res_nxt.data_action = ACT_LSR;
        IID_MSR:  res_nxt.data_action = ACT_MSR;
        IID_RDA:  res_nxt.data_action = ACT_STORE;
        IID_THRE: res_nxt.data_action = ACT_FETCH;
        default:  res_nxt.data_action = ACT_NONE;
      endcase
      if (data_move) begin
        res_nxt.data_address = 32'(cur_addr);
      end
      if (finish) begin
        res_nxt.done_res   = 1'b1;
        res_nxt.done_slot  = 3'(cur_slot);
        res_nxt.tx_int_off = (cur_dir == DIR_WRITE);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_free_r <= '1;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec && submit_ok) begin
        slot_free_r[free_idx] <= 1'b0;
        tail_r                <= ptr_inc(tail_r);
        count_r               <= count_r + CNT_W'(1);
      end
      if (cmd.exec && finish) begin
        slot_free_r[cur_slot] <= 1'b1;
        head_r                <= ptr_inc(head_r);
        count_r               <= count_r - CNT_W'(1);
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_data;
    if (cmd.exec && submit_ok) begin
      slot_addr_r[free_idx] <= ADDR_WIDTH'(in_r.buffer_address);
      slot_rem_r[free_idx]  <= cnt;
      slot_port_r[free_idx] <= in_r.port_sel;
      slot_dir_r[free_idx]  <= in_r.direction;
      fifo_r[tail_r]        <= free_idx;
    end
    if (cmd.exec && data_move) begin
      slot_addr_r[cur_slot] <= cur_addr + ADDR_WIDTH'(1);
      slot_rem_r[cur_slot]  <= rem_dec;
    end
    if (cmd.exec) res_r <= res_nxt;
    // head has advanced by now, so cur_slot is the next request
    if (cmd.start) begin
      res_r.start_valid    <= 1'b1;
      res_r.start_slot     <= 3'(cur_slot);
      res_r.start_io_base  <= port_base(cur_port);
      res_r.start_ier_bits <= (cur_dir == DIR_READ) ? IER_RX : IER_TX;
    end
    if (cmd.push) out_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_matches_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(~slot_free_r) == int'(count_r))
    else $error("busy slot count differs from queue count");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("empty queue with head and tail apart");

  a_submit_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && submit_ok) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("accepted submit did not grow the queue");

  a_start_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> $past(cmd.exec && finish))
    else $error("start report without a finished request");

endmodule
`default_nettype wire

/* tb/utrq_queue_checker.sv */
// ---------------------------------------------------------------------------
// utrq_queue_checker
// Watches both channels of the transfer request queue. Every accepted input
// beat runs through a local model of the descriptor table and the request
// FIFO; the predicted result is queued and compared field by field with the
// result beats as they leave the block.
// ---------------------------------------------------------------------------
module utrq_queue_checker
  import utrq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        mismatches,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 8;

  // descriptor table and request order
  logic [31:0] slot_addr [NSLOT];
  logic [15:0] slot_left [NSLOT];
  logic [1:0]  slot_port [NSLOT];
  logic        slot_dir  [NSLOT];
  logic [NSLOT-1:0] slot_free;
  logic [2:0]  order_q [NSLOT];
  logic [2:0]  head;
  logic [2:0]  tail;
  int          queued;

  out_item_t   expected_results [$];
  out_item_t   want;

  function automatic logic [9:0] io_base_of(input logic [1:0] port);
    case (port)
      2'd0:    return 10'h3F8;
      2'd1:    return 10'h2F8;
      2'd2:    return 10'h3E8;
      default: return 10'h2E8;
    endcase
  endfunction

  function automatic out_item_t with_start(input out_item_t r, input logic [2:0] s);
    out_item_t o;
    o = r;
    o.start_valid    = 1'b1;
    o.start_slot     = s;
    o.start_io_base  = io_base_of(slot_port[s]);
    o.start_ier_bits = (slot_dir[s] == DIR_READ) ? IER_RX : IER_TX;
    return o;
  endfunction

  function automatic out_item_t predict_queue_result(input in_item_t it);
    out_item_t  r;
    logic [2:0] s;
    logic [2:0] cur;
    logic       found;
    int         i;
    r = '0;
    if (it.cmd == CMD_SUBMIT) begin
      if (it.byte_count == 16'd0) begin
        r.status = ST_ZERO_CNT;
      end else begin
        found = 1'b0;
        s = '0;
        // lowest free slot wins
        for (i = NSLOT - 1; i >= 0; i--) begin
          if (slot_free[i]) begin
            s = i[2:0];
            found = 1'b1;
          end
        end
        if (!found) begin
          r.status = ST_FULL;
        end else begin
          slot_addr[s] = it.buffer_address;
          slot_left[s] = it.byte_count;
          slot_port[s] = it.port_sel;
          slot_dir[s]  = it.direction;
          slot_free[s] = 1'b0;
          if (queued == 0) r = with_start(r, s);
          order_q[tail] = s;
          tail = tail + 3'd1;
          queued++;
          r.status = ST_OK;
        end
      end
    end else begin
      if (queued == 0) begin
        r.status = ST_NO_CUR;
      end else if (it.iir_value[0]) begin
        r.status = ST_NOT_PEND;
      end else begin
        cur = order_q[head];
        r.status  = ST_OK;
        r.io_base = io_base_of(slot_port[cur]);
        case (it.iir_value[3:1])
          IID_RLS: r.data_action = ACT_LSR;
          IID_MSR: r.data_action = ACT_MSR;
          IID_RDA, IID_THRE: begin
            r.data_action  = (it.iir_value[3:1] == IID_RDA) ? ACT_STORE : ACT_FETCH;
            r.data_address = slot_addr[cur];
            slot_addr[cur] = slot_addr[cur] + 32'd1;
            slot_left[cur] = slot_left[cur] - 16'd1;
            if (slot_left[cur] == 16'd0) begin
              r.done_res   = 1'b1;
              r.done_slot  = cur;
              r.tx_int_off = (slot_dir[cur] == DIR_WRITE);
              slot_free[cur] = 1'b1;
              head = head + 3'd1;
              queued--;
              if (queued != 0) r = with_start(r, order_q[head]);
            end
          end
          default: ; // unknown ids are accepted but move nothing
        endcase
      end
    end
    return r;
  endfunction

  task automatic compare_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("utrq: %s expected %0h got %0h", fname, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSLOT; k++) begin
        slot_addr[k] = '0;
        slot_left[k] = '0;
        slot_port[k] = '0;
        slot_dir[k]  = '0;
        order_q[k]   = '0;
      end
      slot_free = '1;
      head = '0;
      tail = '0;
      queued = 0;
      expected_results.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(predict_queue_result(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("utrq: result beat with nothing expected");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 32'(want.status), 32'(out_data.status));
          compare_field("data_action", 32'(want.data_action), 32'(out_data.data_action));
          compare_field("data_address", want.data_address, out_data.data_address);
          compare_field("io_base", 32'(want.io_base), 32'(out_data.io_base));
          compare_field("done_res", 32'(want.done_res), 32'(out_data.done_res));
          compare_field("done_slot", 32'(want.done_slot), 32'(out_data.done_slot));
          compare_field("tx_int_off", 32'(want.tx_int_off), 32'(out_data.tx_int_off));
          compare_field("start_valid", 32'(want.start_valid), 32'(out_data.start_valid));
          compare_field("start_slot", 32'(want.start_slot), 32'(out_data.start_slot));
          compare_field("start_io_base", 32'(want.start_io_base),
                        32'(out_data.start_io_base));
          compare_field("start_ier_bits", 32'(want.start_ier_bits),
                        32'(out_data.start_ier_bits));
        end
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Stimulus for the UART transfer request queue: a directed opening that walks
// submits, rejections, every interrupt id and a full table, then a random
// stream of short transfers with interrupt events mixed in. The sender works
// in bursts and the receiver stalls on its own pattern; a checker beside the
// block predicts and compares every result beat.
// ---------------------------------------------------------------------------
module tb;
  import utrq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 1976;
  localparam int IDLE_LIMIT   = 4000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int mismatches;
  int outstanding;
  int burst_left = 0;
  int ready_hold = 0;
  int idle_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  uart_transfer_request_queue_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  utrq_queue_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // receiver: ready stretches of random length broken by short stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      ready_hold <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
      ready_hold <= $urandom_range(0, 30);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  function automatic in_item_t submit_beat(input logic [1:0] port, input logic dir,
                                           input logic [15:0] cnt,
                                           input logic [31:0] addr);
    in_item_t it;
    it = '0;
    it.cmd            = CMD_SUBMIT;
    it.port_sel       = port;
    it.direction      = dir;
    it.byte_count     = cnt;
    it.buffer_address = addr;
    it.iir_value      = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic in_item_t intr_beat(input logic [7:0] iir);
    in_item_t it;
    it = '0;
    it.cmd            = CMD_INTR;
    it.port_sel       = 2'($urandom_range(0, 3));
    it.direction      = 1'($urandom_range(0, 1));
    it.byte_count     = 16'($urandom_range(0, 65535));
    it.buffer_address = $urandom;
    it.iir_value      = iir;
    return it;
  endfunction

  task automatic send_beat(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender until the checker has nothing left waiting
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int         n;
    int         roll;
    int         pick;
    logic [15:0] cnt;
    logic [31:0] addr;
    logic [7:0]  iir;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed opening
    send_beat(intr_beat(8'h00));                                 // nothing current
    send_beat(submit_beat(2'd3, DIR_READ, 16'd0, 32'hFFFF_FFFF)); // zero count
    send_beat(submit_beat(2'd0, DIR_WRITE, 16'd2, 32'hFFFF_FFFF)); // starts, wraps later
    send_beat(submit_beat(2'd1, DIR_READ, 16'd1, 32'h0000_1000));
    send_beat(submit_beat(2'd2, DIR_WRITE, 16'd1, 32'h8000_0000));
    send_beat(submit_beat(2'd3, DIR_READ, 16'd1, 32'h1234_5678));
    send_beat(intr_beat(8'h01));                                 // not pending
    send_beat(intr_beat(8'hFF));
    send_beat(intr_beat({4'h0, IID_MSR, 1'b0}));
    send_beat(intr_beat({4'h0, IID_RLS, 1'b0}));
    send_beat(intr_beat(8'h08));                                 // unknown ids
    send_beat(intr_beat(8'h0A));
    send_beat(intr_beat(8'h0C));
    send_beat(intr_beat(8'h0E));
    send_beat(intr_beat({4'h0, IID_THRE, 1'b0}));
    send_beat(intr_beat({4'hF, IID_RDA, 1'b0}));                 // finishes write
    send_beat(submit_beat(2'd0, DIR_READ, 16'd1, 32'h0000_0000));
    send_beat(submit_beat(2'd1, DIR_WRITE, 16'd1, 32'h5555_AAAA));
    send_beat(submit_beat(2'd2, DIR_READ, 16'd1, 32'hAAAA_5555));
    send_beat(submit_beat(2'd3, DIR_WRITE, 16'd1, 32'h0F0F_F0F0));
    send_beat(submit_beat(2'd0, DIR_WRITE, 16'd1, 32'hF0F0_0F0F)); // table now full
    send_beat(submit_beat(2'd1, DIR_READ, 16'hFFFF, 32'hAAAA_5555));
    send_beat(submit_beat(2'd2, DIR_WRITE, 16'd0, 32'h0000_0001)); // zero before full
    send_beat(intr_beat({4'h0, IID_RDA, 1'b0}));                 // finishes read
    wait_drained();

    // random stream: mostly short transfers drained by data interrupts
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 600 == 300) wait_drained();
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
        pick = $urandom_range(0, 99);
        if (pick < 6)       cnt = 16'd0;
        else if (pick < 8)  cnt = 16'($urandom_range(16, 64));
        else                cnt = 16'($urandom_range(1, 3));
        if ($urandom_range(0, 15) == 0) addr = 32'hFFFF_FFFF - $urandom_range(0, 3);
        else                            addr = $urandom;
        send_beat(submit_beat(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              cnt, addr));
      end else begin
        pick = $urandom_range(0, 99);
        iir[7:4] = 4'($urandom_range(0, 15));
        iir[0] = 1'b0;
        if (pick < 70) begin
          iir[3:1] = $urandom_range(0, 1) ? IID_RDA : IID_THRE;
        end else if (pick < 80) begin
          iir[3:1] = $urandom_range(0, 1) ? IID_RLS : IID_MSR;
        end else if (pick < 90) begin
          iir[3:1] = 3'($urandom_range(4, 7));
        end else begin
          iir[3:1] = 3'($urandom_range(0, 7));
          iir[0] = 1'b1;
        end
        send_beat(intr_beat(iir));
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
